// File: sv/mrd_pkg.sv
package mrd_pkg;

  localparam int unsigned ReqTypeWidth = 2;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned CapWidth     = 9;
  localparam int unsigned StatusWidth  = 3;
  localparam int unsigned CrcWidth     = 16;

  localparam logic [ReqTypeWidth-1:0] REQ_BYTE    = 2'd0;
  localparam logic [ReqTypeWidth-1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [ReqTypeWidth-1:0] REQ_ARM     = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
  localparam logic [StatusWidth-1:0] ST_CRC       = 3'd1;
  localparam logic [StatusWidth-1:0] ST_EXCEPTION = 3'd2;
  localparam logic [StatusWidth-1:0] ST_NO_RESP   = 3'd3;
  localparam logic [StatusWidth-1:0] ST_INCOMPL   = 3'd4;
  localparam logic [StatusWidth-1:0] ST_TOO_LONG  = 3'd5;
  localparam logic [StatusWidth-1:0] ST_UNKNOWN   = 3'd6;

  localparam logic [CrcWidth-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CrcWidth-1:0]  CRC_POLY = 16'hA001;

  localparam logic [ByteWidth-1:0] FC_EXC_BIT    = 8'h80;
  localparam logic [ByteWidth-1:0] FC_READ_COILS = 8'h01;
  localparam logic [ByteWidth-1:0] FC_READ_INPUT = 8'h04;
  localparam logic [ByteWidth-1:0] FC_WRITE_COIL = 8'h05;
  localparam logic [ByteWidth-1:0] FC_WRITE_REG  = 8'h06;
  localparam logic [ByteWidth-1:0] FC_WRITE_MULT = 8'h10;

  localparam logic [CapWidth-1:0] WRITE_PDU_LEN = 9'd5;
  localparam logic [CapWidth-1:0] ECHO_LEN      = 9'd4;

  typedef enum logic [1:0] {
    EV_BYTE,
    EV_TIMEOUT,
    EV_ARM
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t             kind;
    logic [ByteWidth-1:0] data;
  } event_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc_in,
                                                    input logic [ByteWidth-1:0] b);
    logic [CrcWidth-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: sv/mrd_front.sv
module mrd_front
  import mrd_pkg::*;
(
  input  logic [ReqTypeWidth-1:0] req_type,
  input  logic [ByteWidth-1:0]    rx_byte,
  input  logic                    req_valid,
  output logic                    push,
  output event_t                  ev
);

  // unknown request types are dropped here
  always_comb begin
    ev.data = rx_byte;
    ev.kind = EV_BYTE;
    push    = 1'b0;
    case (req_type)
      REQ_BYTE: begin
        ev.kind = EV_BYTE;
        push    = req_valid;
      end
      REQ_TIMEOUT: begin
        ev.kind = EV_TIMEOUT;
        push    = req_valid;
      end
      REQ_ARM: begin
        ev.kind = EV_ARM;
        push    = req_valid;
      end
      default: begin
        ev.kind = EV_BYTE;
        push    = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/mrd_queue.sv
module mrd_queue
  import mrd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  event_t  push_ev,
  input  logic    pop,
  output event_t  head_ev,
  output q_stat_t stat
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  event_t                mem_r [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrWidth-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntWidth-1:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == FullCnt);
  assign head_ev    = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_ev;
  end

endmodule

// File: sv/mrd_back.sv
module mrd_back
  import mrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CapWidth-1:0]    capacity,
  input  q_stat_t                q_stat,
  input  event_t                 head_ev,
  output logic                   pop,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_last,
  output logic [ByteWidth-1:0]   out_byte,
  output logic [StatusWidth-1:0] out_status,
  output logic [ByteWidth-1:0]   out_exc
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_FUNC   = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_EXC    = 3'd5;
  localparam logic [2:0] PH_CRC_LO = 3'd6;
  localparam logic [2:0] PH_CRC_HI = 3'd7;

  logic [2:0]             phase_r, phase_nxt;
  logic [CrcWidth-1:0]    crc_r, crc_nxt;
  logic [CrcWidth-1:0]    crc_end_r, crc_end_nxt;
  logic [ByteWidth-1:0]   func_r, func_nxt;
  logic [CapWidth-1:0]    left_r, left_nxt;
  logic [ByteWidth-1:0]   crc_lo_r, crc_lo_nxt;
  logic [ByteWidth-1:0]   exc_r, exc_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [ByteWidth-1:0]   out_byte_r, out_byte_nxt;
  logic [StatusWidth-1:0] out_status_r, out_status_nxt;
  logic [ByteWidth-1:0]   out_exc_r, out_exc_nxt;

  logic                   emit, emit_last;
  logic [ByteWidth-1:0]   emit_byte;
  logic [StatusWidth-1:0] emit_status;
  logic [ByteWidth-1:0]   emit_exc;
  logic [CrcWidth-1:0]    crc_upd;
  logic [CapWidth-1:0]    left_dec;
  logic                   is_write_fc;
  logic [ByteWidth-1:0]   b;

  assign pop         = q_stat.valid && (!out_valid_r || out_ready);
  assign b           = head_ev.data;
  assign crc_upd     = crc_byte(crc_r, b);
  assign left_dec    = (left_r != '0) ? left_r - 1'b1 : left_r;
  assign is_write_fc = (func_r == FC_WRITE_COIL) || (func_r == FC_WRITE_REG) ||
                       (func_r == FC_WRITE_MULT);

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    crc_end_nxt = crc_end_r;
    func_nxt    = func_r;
    left_nxt    = left_r;
    crc_lo_nxt  = crc_lo_r;
    exc_nxt     = exc_r;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_byte   = '0;
    emit_status = ST_OK;
    emit_exc    = '0;
    if (pop) begin
      if (head_ev.kind == EV_ARM) begin
        phase_nxt = PH_ADDR;
        crc_nxt   = CRC_INIT;
        left_nxt  = '0;
      end else if (phase_r == PH_IDLE) begin
        phase_nxt = PH_IDLE;
      end else if (head_ev.kind == EV_TIMEOUT) begin
        emit        = 1'b1;
        emit_last   = 1'b1;
        emit_status = (phase_r == PH_ADDR || phase_r == PH_FUNC) ? ST_NO_RESP : ST_INCOMPL;
        phase_nxt   = PH_IDLE;
      end else begin
        case (phase_r)
          PH_ADDR: begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_FUNC;
          end
          PH_FUNC: begin
            crc_nxt  = crc_upd;
            func_nxt = b;
            if ((b & FC_EXC_BIT) != '0) begin
              phase_nxt = PH_EXC;
            end else if (b >= FC_READ_COILS && b <= FC_READ_INPUT) begin
              phase_nxt = PH_COUNT;
              emit      = 1'b1;
              emit_byte = b;
            end else if (b == FC_WRITE_COIL || b == FC_WRITE_REG || b == FC_WRITE_MULT) begin
              left_nxt  = ECHO_LEN;
              phase_nxt = PH_DATA;
              emit      = 1'b1;
              emit_byte = b;
            end else begin
              emit        = 1'b1;
              emit_last   = 1'b1;
              emit_status = ST_UNKNOWN;
              phase_nxt   = PH_IDLE;
            end
          end
          PH_COUNT: begin
            crc_nxt = crc_upd;
            if ({2'b00, b} + 10'd2 > {1'b0, capacity}) begin
              emit        = 1'b1;
              emit_last   = 1'b1;
              emit_status = ST_TOO_LONG;
              phase_nxt   = PH_IDLE;
            end else begin
              left_nxt  = {1'b0, b};
              emit      = 1'b1;
              emit_byte = b;
              if (b == '0) begin
                crc_end_nxt = crc_upd;
                phase_nxt   = PH_CRC_LO;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            crc_nxt   = crc_upd;
            left_nxt  = left_dec;
            emit      = 1'b1;
            emit_byte = b;
            if (left_dec == '0) begin
              crc_end_nxt = crc_upd;
              phase_nxt   = PH_CRC_LO;
            end
          end
          PH_EXC: begin
            crc_nxt     = crc_upd;
            exc_nxt     = b;
            crc_end_nxt = crc_upd;
            phase_nxt   = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            crc_lo_nxt = b;
            phase_nxt  = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            phase_nxt = PH_IDLE;
            if ({b, crc_lo_r} != crc_end_r) begin
              emit_status = ST_CRC;
            end else if ((func_r & FC_EXC_BIT) != '0) begin
              emit_status = ST_EXCEPTION;
              emit_exc    = exc_r;
            end else if (is_write_fc && capacity < WRITE_PDU_LEN) begin
              emit_status = ST_TOO_LONG;
            end else begin
              emit_status = ST_OK;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_last_nxt   = out_last_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_exc_nxt    = out_exc_r;
    if (pop && emit) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = emit_last;
      out_byte_nxt   = emit_byte;
      out_status_nxt = emit_status;
      out_exc_nxt    = emit_exc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      crc_r       <= CRC_INIT;
      crc_end_r   <= CRC_INIT;
      func_r      <= '0;
      left_r      <= '0;
      crc_lo_r    <= '0;
      exc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      crc_end_r   <= crc_end_nxt;
      func_r      <= func_nxt;
      left_r      <= left_nxt;
      crc_lo_r    <= crc_lo_nxt;
      exc_r       <= exc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_last_r   <= out_last_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_exc_r    <= out_exc_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_last   = out_last_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_exc    = out_exc_r;

endmodule

// File: sv/modbus_rtu_response_deframer.sv
// Modbus RTU response deframer, master side.
// Input stream: one request per event. in_tuser gives the kind (0 received byte,
// 1 receive timeout, 2 arm after a request was sent), in_tdata the received byte.
// Output stream: PDU bytes of a normal frame leave as they arrive, then one status
// result with out_tlast high closes the frame (ok, crc error, exception, no
// response, incomplete, too long, unknown function). Drop the PDU unless ok.
// cfg_we/cfg_wdata write the response capacity (largest PDU length), reset 256;
// write it only while the block is idle.
// Throughput: one request per cycle while in_tready is high. A result passes the
// queue stage, then the output register, before it is valid; the byte-wide CRC
// update and parse step in the back end lies combinationally between them.
// Reset leaves the block disarmed with an empty queue and no result pending.
// When the receiver stalls the result holds in the output register, the back end
// stops, the event queue fills, and in_tready falls once QUEUE_DEPTH requests wait.
module modbus_rtu_response_deframer
  import mrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pdu_byte, frame_status, slave_exc, zero pad
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  logic [CapWidth-1:0]    capacity_r;
  logic                   f_push, q_push, q_pop;
  event_t                 f_ev, head_ev;
  q_stat_t                q_stat;
  logic [ByteWidth-1:0]   o_byte, o_exc;
  logic [StatusWidth-1:0] o_status;

  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= 9'd256;
    else if (cfg_we) capacity_r <= cfg_wdata;
  end

  assign in_tready = !q_stat.full;
  assign q_push    = f_push && in_tready;

  mrd_front u_front (
    .req_type  (in_tuser),
    .rx_byte   (in_tdata),
    .req_valid (in_tvalid),
    .push      (f_push),
    .ev        (f_ev)
  );

  mrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ev (f_ev),
    .pop     (q_pop),
    .head_ev (head_ev),
    .stat    (q_stat)
  );

  mrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (capacity_r),
    .q_stat     (q_stat),
    .head_ev    (head_ev),
    .pop        (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_last   (out_tlast),
    .out_byte   (o_byte),
    .out_status (o_status),
    .out_exc    (o_exc)
  );

  assign out_tdata = {5'b00000, o_exc, o_status, o_byte};

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'h00)
    else $error("status result carries a pdu byte");

  a_byte_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[18:8] == 11'h000)
    else $error("pdu byte result carries status");

  a_exc_only_exception: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] != ST_EXCEPTION |-> out_tdata[18:11] == 8'h00)
    else $error("exception code outside exception status");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_tvalid || out_tready))
    else $error("back end advanced over a stalled result");

endmodule
